### rtl/core/angle_unwrap_fir_smoother_assert.svh
// Assertion macros for the angle smoother.
// Define NO_ASSERTIONS to compile them out.
`ifndef ANGLE_UNWRAP_FIR_SMOOTHER_ASSERT_SVH
`define ANGLE_UNWRAP_FIR_SMOOTHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked out of reset.
`define AUFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define AUFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AUFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define AUFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define AUFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define AUFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/aufs_pkg.sv
`default_nettype none

package aufs_pkg;

  localparam int ANGLE_W = 15;   // Q12 input angle
  localparam int UNW_W   = 17;   // unwrapped sample
  localparam int TAP_W   = 16;   // Q14 coefficient
  localparam int PROD_W  = TAP_W + UNW_W;
  localparam int ACC_W   = 37;   // Q26 sum of up to seven products
  localparam int OUT_W   = 16;
  localparam int CNT_W   = 3;
  localparam int NUM_TAPS = 7;
  localparam int FRAC_SHIFT = 14;

  localparam logic [CNT_W-1:0] COUNT_SAT = 3'd7;

  localparam logic signed [15:0]    PI_Q12     = 16'sd12868;
  localparam logic signed [UNW_W-1:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 37'sd8192;

  // configuration register indexes
  localparam int REG_IDX_W = 4;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_FIRST  = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAP_LAST   = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_MAC,
    ST_DRAIN
  } aufs_state_e;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic issue;   // push one tap into the pipe
  } aufs_mac_ctl_t;

endpackage

`default_nettype wire

### rtl/core/aufs_mac.sv
`default_nettype none

// Shared unwrap / multiply / accumulate pipe with round and saturate.
module aufs_mac
  import aufs_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire aufs_mac_ctl_t               ctl_i,
  input  wire logic signed [ANGLE_W-1:0]   sample_i,
  input  wire logic signed [ANGLE_W-1:0]   centre_i,
  input  wire logic signed [TAP_W-1:0]     tap_i,
  output logic                             busy_o,
  output logic signed [OUT_W-1:0]          result_o
);

  logic                        v1_q, v2_q;
  logic signed [UNW_W-1:0]     b_q, b_d;
  logic signed [TAP_W-1:0]     tap_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [15:0]          diff;
  logic signed [UNW_W-1:0]     s_ext;
  logic signed [ACC_W-1:0]     rounded;
  logic signed [ACC_W-FRAC_SHIFT-1:0] quot;

  // stage 1: unwrap against the centre sample
  always_comb begin
    diff  = 16'(sample_i) - 16'(centre_i);
    s_ext = UNW_W'(sample_i);
    if (diff > PI_Q12) begin
      b_d = s_ext - TWO_PI_Q12;
    end else if (diff < -PI_Q12) begin
      b_d = s_ext + TWO_PI_Q12;
    end else begin
      b_d = s_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      b_q   <= b_d;
      tap_q <= tap_i;
    end
    if (v1_q) begin
      prod_q <= PROD_W'(tap_q * b_q);
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign busy_o = v1_q | v2_q;

  // round half up to Q12, then saturate
  always_comb begin
    rounded = acc_q + ROUND_HALF;
    quot    = rounded[ACC_W-1:FRAC_SHIFT];
    if (quot > (ACC_W-FRAC_SHIFT)'(32767)) begin
      result_o = 16'sh7fff;
    end else if (quot < -(ACC_W-FRAC_SHIFT)'(32768)) begin
      result_o = -16'sh8000;
    end else begin
      result_o = quot[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/angle_unwrap_fir_smoother.sv
// An item that yields a result holds off the next input until the sequencer is back in idle,
//   after the result has entered the output register; an item that yields none leaves
//   the input ready. Results come from the single shared tap pipe, which takes one tap
//   per cycle.
// Reset: rst_ni asynchronous, active low; clears window, counters and output valid,
//   loads half_width = 2 and a unit centre tap.
`default_nettype none

module angle_unwrap_fir_smoother
  import aufs_pkg::*;
#(
  parameter int MAX_TAPS = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration writes
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [TAP_W-1:0]          cfg_data_i,
  // input samples
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [ANGLE_W-1:0] angle_in_i,
  input  wire logic                      is_last_i,
  // smoothed results
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [OUT_W-1:0]        smoothed_angle_o,
  output logic                           end_of_run_o
);

  localparam int WIN_AW = $clog2(MAX_TAPS);
  localparam int HMAX   = (MAX_TAPS - 1) / 2;
  localparam logic [2:0] HMAX_V     = 3'(HMAX);
  localparam logic [4:0] MAX_TAPS_V = 5'(MAX_TAPS);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land at once; the port never stalls.
  // ---------------------------------------------------------------------------
  logic [1:0]                half_width_q;
  logic signed [TAP_W-1:0]   taps_q [NUM_TAPS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= 2'd2;
      for (int i = 0; i < NUM_TAPS; i++) begin
        taps_q[i] <= (i == 2) ? 16'sd16384 : 16'sd0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_HALF_WIDTH) begin
        half_width_q <= cfg_data_i[1:0];
      end else if (cfg_index_i >= REG_TAP_FIRST && cfg_index_i <= REG_TAP_LAST) begin
        taps_q[3'(cfg_index_i - REG_TAP_FIRST)] <= cfg_data_i;
      end
      // indexes past the last tap are dropped
    end
  end

  // Effective half width, clipped to what the window can hold.
  logic [1:0] h;
  assign h = ({1'b0, half_width_q} > HMAX_V) ? HMAX_V[1:0] : half_width_q;

  // ---------------------------------------------------------------------------
  // Sample history: window (newest at entry 0), first sample of the run, and
  // the saturating count of samples seen in this run.
  // ---------------------------------------------------------------------------
  logic signed [ANGLE_W-1:0] window_q [MAX_TAPS];
  logic signed [ANGLE_W-1:0] first_q, first_d;
  logic [CNT_W-1:0]          seen_q, seen_d, seen_next;
  logic                      win_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        window_q[i] <= '0;
      end
    end else if (win_shift) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        window_q[i] <= window_q[i-1];
      end
      window_q[0] <= angle_in_i;
    end
  end

  assign seen_next = (seen_q == COUNT_SAT) ? COUNT_SAT : seen_q + 3'd1;

  // ---------------------------------------------------------------------------
  // Sequencer. Per result: the centre state latches the centre sample, the MAC
  // state issues the taps in turn into the shared pipe, then a drain waits until
  // the sum settles and the output register is free.
  // ---------------------------------------------------------------------------
  aufs_state_e               state_q, state_d;
  logic [2:0]                k_q, k_d;
  logic [1:0]                delay_q, delay_d;
  logic                      last_q, last_d;
  logic signed [ANGLE_W-1:0] centre_q;
  logic [2:0]                n_new;
  logic [2:0]                k_end;
  aufs_mac_ctl_t             mac_ctl;
  logic                      mac_busy;
  logic signed [OUT_W-1:0]   mac_result;
  logic                      out_load;
  logic                      out_valid_q;
  logic signed [OUT_W-1:0]   smoothed_q;
  logic                      eor_q;

  assign n_new = seen_next - 3'd1;
  assign k_end = {h, 1'b0};

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    delay_d   = delay_q;
    last_d    = last_q;
    seen_d    = seen_q;
    first_d   = first_q;
    win_shift = 1'b0;
    in_ready_o = 1'b0;
    mac_ctl   = '0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          win_shift = 1'b1;
          if (seen_q == '0) begin
            first_d = angle_in_i;
          end
          seen_d = seen_next;
          last_d = is_last_i;
          if (is_last_i) begin
            // flush: centres from min(n, h) samples back down to the newest
            delay_d = (n_new >= {1'b0, h}) ? h : n_new[1:0];
            state_d = ST_CENTRE;
          end else if (n_new >= {1'b0, h}) begin
            delay_d = h;
            state_d = ST_CENTRE;
          end
        end
      end
      ST_CENTRE: begin
        mac_ctl.clear = 1'b1;
        k_d     = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_ctl.issue = 1'b1;
        if (k_q == k_end) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          if (last_q && delay_q != 2'd0) begin
            delay_d = delay_q - 2'd1;
            state_d = ST_CENTRE;
          end else begin
            state_d = ST_IDLE;
            if (last_q) begin
              seen_d = '0;  // next transfer opens a new run
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      delay_q <= '0;
      last_q  <= 1'b0;
      seen_q  <= '0;
      first_q <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      delay_q <= delay_d;
      last_q  <= last_d;
      seen_q  <= seen_d;
      first_q <= first_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Window read: one shared port. In the centre cycle the age is the delay,
  // in tap cycles it is delay - h + k. Negative age (past the end) reuses the
  // newest sample; ages beyond what the run has seen reuse the first sample.
  // ---------------------------------------------------------------------------
  logic signed [4:0]         age;
  logic [WIN_AW-1:0]         win_idx;
  logic signed [ANGLE_W-1:0] rd_sample;

  always_comb begin
    if (state_q == ST_CENTRE) begin
      age = $signed({3'b000, delay_q});
    end else begin
      age = $signed({3'b000, delay_q}) - $signed({3'b000, h}) + $signed({2'b00, k_q});
    end
    win_idx = WIN_AW'(age[3:0]);
    if (age < 0) begin
      rd_sample = window_q[0];
    end else if (age >= $signed({2'b00, seen_q}) || age[4:0] >= MAX_TAPS_V) begin
      rd_sample = first_q;
    end else begin
      rd_sample = window_q[win_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CENTRE) begin
      centre_q <= rd_sample;
    end
  end

  aufs_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (rd_sample),
    .centre_i (centre_q),
    .tap_i    (taps_q[k_q]),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds one result so the input side can move on while
  // the consumer stalls.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      smoothed_q <= mac_result;
      eor_q      <= last_q && (delay_q == 2'd0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_angle_o = smoothed_q;
  assign end_of_run_o     = eor_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "angle_unwrap_fir_smoother_assert.svh"

  `AUFS_ASSERT_IMPLY(a_idle_pipe_empty, clk_i, rst_ni, state_q == ST_IDLE, !mac_busy, "tap pipe busy while idle")
  `AUFS_ASSERT_IMPLY(a_tap_in_span, clk_i, rst_ni, state_q == ST_MAC, k_q <= k_end, "tap index past kernel span")
  `AUFS_ASSERT_NEXT(a_run_end_clears, clk_i, rst_ni, out_load && last_q && delay_q == 2'd0, seen_q == '0 && state_q == ST_IDLE, "run not closed after final result")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aufs_pkg::*;

  // Run shape
  localparam int STALL_MAX      = 17;    // longest random gap per item, either side
  localparam int HOLD_CYCLES    = 400;   // one long output hold-off to back up the block
  localparam int DRAIN_CYCLES   = 20;    // covers a sample still in flight
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is declared hung
  localparam int MAX_REPORTS    = 200;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 40;
  localparam int HALF_MAX       = (NUM_TAPS - 1) / 2;
  localparam int TAP_POS_MAX    = 32767;
  localparam int TAP_NEG_MAX    = -32768;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle;
    logic                    end_run;
  } smooth_res_t;

  // Scoreboard: keeps its own copy of the window and the filter registers and
  // predicts the smoothed angles that each sample transfer releases.
  class angle_smooth_sb;
    int unsigned half_w;
    int          coef[NUM_TAPS];
    int          hist[NUM_TAPS];   // newest sample at entry 0
    int          first_s;
    int unsigned seq_count;        // samples of the open sequence, saturating
    smooth_res_t expected_q[$];
    int          errors;
    int          n_in;
    int          n_out;

    function new();
      half_w = 2;
      foreach (coef[k]) coef[k] = 0;
      coef[2] = 16384;
      foreach (hist[k]) hist[k] = 0;
      first_s = 0;
      seq_count = 0;
      errors = 0;
      n_in = 0;
      n_out = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [TAP_W-1:0] data);
      if (idx == REG_HALF_WIDTH) begin
        half_w = data[1:0];
      end else if (idx >= REG_TAP_FIRST && idx <= REG_TAP_LAST) begin
        coef[idx - REG_TAP_FIRST] = int'($signed(data));
      end
    endfunction

    // Before the sequence start: first sample; past the newest: newest sample.
    function int hist_at(int age);
      if (age < 0) return hist[0];
      if (age >= int'(seq_count) || age >= NUM_TAPS) return first_s;
      return hist[age];
    endfunction

    function smooth_res_t smooth_at(int h, int delay, bit is_end);
      int          centre;
      int          s;
      longint      acc;
      longint      v;
      smooth_res_t r;
      centre = hist_at(delay);
      acc = 0;
      for (int k = 0; k <= 2 * h && k < NUM_TAPS; k++) begin
        s = hist_at(delay - (h - k));
        // unwrap against the centre sample
        if (s - centre > int'(PI_Q12)) begin
          s -= int'(TWO_PI_Q12);
        end else if (s - centre < -int'(PI_Q12)) begin
          s += int'(TWO_PI_Q12);
        end
        acc += longint'(coef[k]) * longint'(s);
      end
      // Q26 -> Q12, halves toward +inf, then saturate
      v = (acc + longint'(ROUND_HALF)) >>> FRAC_SHIFT;
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      r.angle = v[OUT_W-1:0];
      r.end_run = is_end;
      return r;
    endfunction

    function void note_input(logic signed [ANGLE_W-1:0] ang, logic last);
      int h;
      int n;
      h = (half_w > HALF_MAX) ? HALF_MAX : int'(half_w);
      n_in++;
      for (int i = NUM_TAPS - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = int'(ang);
      if (seq_count == 0) first_s = hist[0];
      if (seq_count < COUNT_SAT) seq_count++;
      n = int'(seq_count) - 1;
      if (last) begin
        // flush every pending output, oldest centre first
        for (int d = (n >= h) ? h : n; d >= 0; d--) begin
          expected_q.push_back(smooth_at(h, d, d == 0));
        end
        seq_count = 0;
      end else if (n >= h) begin
        expected_q.push_back(smooth_at(h, h, 1'b0));
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] ang, logic eor);
      smooth_res_t want;
      n_out++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result %0d unexpected: smoothed_angle %0d end_of_run %0b",
                   $time, n_out, ang, eor);
        end
        return;
      end
      want = expected_q.pop_front();
      if (ang !== want.angle || eor !== want.end_run) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result %0d: smoothed_angle exp %0d got %0d, end_of_run exp %0b got %0b",
                   $time, n_out, $signed(want.angle), ang, want.end_run, eor);
        end
      end
    endfunction
  endclass

  // DUT signals; every input starts at a known value
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [REG_IDX_W-1:0]          cfg_index_i = '0;
  logic [TAP_W-1:0]              cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic signed [ANGLE_W-1:0]     angle_in_i  = '0;
  logic                          is_last_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [OUT_W-1:0]       smoothed_angle_o;
  logic                          end_of_run_o;

  angle_smooth_sb sb;
  bit tx_calm     = 1'b0;   // sender offers back to back
  bit rx_calm     = 1'b0;   // receiver always ready
  bit rx_hold_req = 1'b0;   // ask the receiver for one long hold-off
  int n_settings  = 0;
  int quiet_cycles = 0;

  angle_unwrap_fir_smoother i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .angle_in_i       (angle_in_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .smoothed_angle_o (smoothed_angle_o),
    .end_of_run_o     (end_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Transfer monitor: sampled at the edge, before any of this edge's updates land.
  // Results are checked before the sample of the same edge is noted; a sample can
  // never release a result in the cycle it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(smoothed_angle_o, end_of_run_o);
      if (in_valid_i && in_ready_o) sb.note_input(angle_in_i, is_last_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, quiet_cycles, sb.expected_q.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stall before each result, or none in calm stretches;
  // on request one long hold-off so the block backs up and stalls its input.
  initial begin
    int unsigned pause;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pause = rx_calm ? 0 : $urandom_range(STALL_MAX, 0);
      if (rx_hold_req) begin
        pause += HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (pause != 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // One sample transfer. Valid is only lowered when a gap is drawn, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic send_sample(input logic signed [ANGLE_W-1:0] ang, input logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(STALL_MAX, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_in_i <= ang;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_run(input int vals[$]);
    for (int i = 0; i < vals.size(); i++) begin
      send_sample(ANGLE_W'(vals[i]), i == vals.size() - 1);
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TAP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Full register set; optional junk above the half width bits and a stray
  // write to an unmapped index, which must be ignored.
  task automatic program_filter(input int hw, input int coef[NUM_TAPS],
                                input bit junk_bits, input bit stray);
    if (junk_bits) write_reg(REG_HALF_WIDTH, TAP_W'(($urandom() & 32'hFFFC) | hw));
    else write_reg(REG_HALF_WIDTH, TAP_W'(hw));
    for (int k = 0; k < NUM_TAPS; k++) begin
      write_reg(REG_TAP_FIRST + REG_IDX_W'(k), TAP_W'(coef[k]));
    end
    if (stray) write_reg(REG_TAP_LAST + REG_IDX_W'($urandom_range(8, 1)), TAP_W'($urandom()));
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Wait one edge first so the monitor has seen the last sample transfer,
  // then until nothing is due, then past any sample that releases nothing.
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int draw_tap(bit wide);
    if (wide) return int'($urandom_range(65535, 0)) - 32768;
    return int'($urandom_range(12288, 0)) - 4096;
  endfunction

  // Random sequences: smooth trajectories that wrap across +-pi and uniform in-range
  // angles, with angles parked near pi and raw 15-bit noise mixed in.
  // The phase can end inside a sequence, so the next setting lands mid-sequence.
  task automatic random_phase(input int n_items);
    int seq_left;
    int ang;
    int prev;
    int sel;
    seq_left = 0;
    prev = 0;
    for (int i = 0; i < n_items; i++) begin
      if (seq_left == 0) begin
        seq_left = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : $urandom_range(14, 1);
      end
      sel = $urandom_range(9, 0);
      if (sel == 0) begin
        ang = int'($urandom_range(32767, 0)) - 16384;
      end else if (sel == 1) begin
        ang = int'(PI_Q12) - int'($urandom_range(40, 0));
        if ($urandom_range(1, 0) == 1) ang = -ang;
      end else if (sel <= 5) begin
        ang = prev + int'($urandom_range(3000, 0)) - 1500;
        if (ang > int'(PI_Q12)) ang -= int'(TWO_PI_Q12);
        else if (ang < -int'(PI_Q12)) ang += int'(TWO_PI_Q12);
      end else begin
        ang = int'($urandom_range(25736, 0)) - int'(PI_Q12);
      end
      prev = ang;
      seq_left--;
      send_sample(ANGLE_W'(ang), seq_left == 0);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int seq_q[$];
    int coef[NUM_TAPS];
    int hw;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting (h = 2, unit centre tap): wrap extremes, out-of-range
    // patterns, a single-sample sequence and a two-sample one.
    seq_q = '{0, 12868, -12868, 16383, -16384};
    send_run(seq_q);
    seq_q = '{100};
    send_run(seq_q);
    seq_q = '{200, -300};
    send_run(seq_q);
    in_valid_i <= 1'b0;
    wait_drained();

    // h = 1 smoothing kernel; taps past 2h loaded with extremes must not count.
    coef = '{4096, 8192, 4096, TAP_POS_MAX, TAP_NEG_MAX, TAP_POS_MAX, TAP_NEG_MAX};
    program_filter(1, coef, 1'b0, 1'b1);
    seq_q = '{12000, -12000, 12500, -12800, 0, 12868, 3000, -3000};
    send_run(seq_q);
    in_valid_i <= 1'b0;
    wait_drained();

    // Widest kernel, alternating extreme taps: saturation both ways and a
    // sequence long enough to saturate the sample count.
    coef = '{TAP_POS_MAX, TAP_NEG_MAX, TAP_POS_MAX, TAP_NEG_MAX,
             TAP_POS_MAX, TAP_NEG_MAX, TAP_POS_MAX};
    program_filter(HALF_MAX, coef, 1'b1, 1'b0);
    seq_q = '{16383, -16384, 16383, -16384, 12868, -12868, 1, -1, 0};
    send_run(seq_q);
    in_valid_i <= 1'b0;
    wait_drained();

    // Random part: one setting per phase, the extremes first.
    for (int p = 0; p < RAND_PHASES; p++) begin
      hw = $urandom_range(3, 0);
      for (int k = 0; k < NUM_TAPS; k++) coef[k] = draw_tap(p % 2 == 0);
      if (p == 0) begin
        hw = 0;
      end else if (p == 1) begin
        hw = HALF_MAX;
        foreach (coef[k]) coef[k] = TAP_POS_MAX;
      end else if (p == 2) begin
        hw = HALF_MAX;
        foreach (coef[k]) coef[k] = TAP_NEG_MAX;
      end
      program_filter(hw, coef, $urandom_range(1, 0), $urandom_range(2, 0) == 0);
      // phase 4: sender streams while the receiver holds off; phase 6: no idling
      tx_calm = (p == 4) || (p == 6);
      rx_calm = (p == 6);
      if (p == 4) rx_hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
      wait_drained();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end

    $display("tb_top: %0d samples, %0d smoothed results checked over %0d filter settings",
             sb.n_in, sb.n_out, n_settings);
    $display("tb_top: half widths 0..3, extreme taps, wrap and 15-bit noise angles, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
